// ----- src/cconv_pkg.sv -----
// ---------------------------------------------------------------------------
// Causal convolution package
// Shared types, constants and field layouts for the causal convolution core.
// ---------------------------------------------------------------------------
package cconv_pkg;

    // Kernel length and the widths that follow from it.
    localparam int TAPS  = 32;
    localparam int IDX_W = $clog2(TAPS);
    localparam int POS_W = $clog2(TAPS + 1);

    // Q1.31 fixed point: 1.0 is 2^31.
    localparam int          DATA_W  = 32;
    localparam logic [31:0] ONE_Q31 = 32'h8000_0000;

    // Command codes of an input item.
    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_PUSH = 1'b1;

    typedef struct packed {
        logic        command;
        logic [4:0]  tap_index;
        logic [31:0] value;
        logic        last_of_column;
    } in_item_t;

    typedef struct packed {
        logic [31:0] result;
        logic        column_end;
        logic        overflow;
    } out_item_t;

    // Write side of the kernel and history stores.
    typedef struct packed {
        logic              kern_we;
        logic              hist_we;
        logic [IDX_W-1:0]  waddr;
        logic [DATA_W-1:0] wdata;
    } store_wr_t;

    // Read addresses of the kernel and history stores.
    typedef struct packed {
        logic [IDX_W-1:0] hist_addr;
        logic [IDX_W-1:0] kern_addr;
    } store_rd_t;

    // Control of the multiply-accumulate unit.
    typedef struct packed {
        logic clr;
        logic op_valid;
    } mac_ctl_t;

endpackage

// ----- src/cconv_store.sv -----
// ---------------------------------------------------------------------------
// Causal convolution stores
// Kernel and column history memories with registered reads.
// ---------------------------------------------------------------------------
module cconv_store (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cconv_pkg::store_wr_t          wr,
    input  cconv_pkg::store_rd_t          rd,
    output logic [cconv_pkg::DATA_W-1:0]  hist_rdata,
    output logic [cconv_pkg::DATA_W-1:0]  kern_rdata
);

    logic [cconv_pkg::DATA_W-1:0] kern_mem [cconv_pkg::TAPS];
    logic [cconv_pkg::DATA_W-1:0] hist_mem [cconv_pkg::TAPS];
    logic [cconv_pkg::TAPS-1:0]   kern_vld_reg;
    logic [cconv_pkg::DATA_W-1:0] kern_q_reg;
    logic                         kern_v_reg;
    logic [cconv_pkg::DATA_W-1:0] hist_q_reg;

    // A kernel tap that was never loaded reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            kern_vld_reg <= '0;
        end else if (wr.kern_we) begin
            kern_vld_reg[wr.waddr] <= 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (wr.kern_we) begin
            kern_mem[wr.waddr] <= wr.wdata;
        end
        if (wr.hist_we) begin
            hist_mem[wr.waddr] <= wr.wdata;
        end
        kern_q_reg <= kern_mem[rd.kern_addr];
        kern_v_reg <= kern_vld_reg[rd.kern_addr];
        hist_q_reg <= hist_mem[rd.hist_addr];
    end

    assign kern_rdata = kern_v_reg ? kern_q_reg : '0;
    assign hist_rdata = hist_q_reg;

endmodule

// ----- src/cconv_mac.sv -----
// ---------------------------------------------------------------------------
// Causal convolution multiply-accumulate
// Two-stage Q1.31 multiply with truncation and a saturating accumulator.
// ---------------------------------------------------------------------------
module cconv_mac (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  cconv_pkg::mac_ctl_t           ctl,
    input  logic [cconv_pkg::DATA_W-1:0]  op_a,
    input  logic [cconv_pkg::DATA_W-1:0]  op_b,
    output logic [cconv_pkg::DATA_W-1:0]  result
);

    logic [63:0] prod_reg;
    logic        pv_reg;
    logic [30:0] acc_reg;
    logic        sat_reg;
    logic [33:0] sum;

    // The accumulator stays below 1.0 until it saturates, so 31 bits suffice.
    assign sum = {3'b000, acc_reg} + {1'b0, prod_reg[63:31]};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pv_reg <= 1'b0;
        end else begin
            pv_reg <= ctl.op_valid;
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= 64'(op_a) * 64'(op_b);
        if (ctl.clr) begin
            acc_reg <= '0;
            sat_reg <= 1'b0;
        end else if (pv_reg && !sat_reg) begin
            acc_reg <= sum[30:0];
            sat_reg <= (sum[33:31] != 3'b000);
        end
    end

    assign result = sat_reg ? cconv_pkg::ONE_Q31 : {1'b0, acc_reg};

endmodule

// ----- src/causal_kernel_convolution_core.sv -----
// ---------------------------------------------------------------------------
// Causal kernel convolution core
// Loads a kernel of Q1.31 weights and convolves column samples causally.
// ---------------------------------------------------------------------------
// A load item (command 0) writes one kernel weight and gives no result. A
// sample item (command 1) at column position i is stored in the history
// and answered with the sum over n = 0..i of sample[n] times kernel[i-n],
// each product truncated to Q1.31 and the sum saturated at 1.0. The one
// multiplier issues one product per cycle while a sample is issued. A
// sample at position i passes through the accepting state, the issue of
// i + 1 reads, the memory read and multiply registers, and the hand-over
// of the result to the output register. A sample that arrives after the
// column already holds TAPS samples is dropped and answered with a zero
// result and the overflow bit set. The last-of-column flag on a sample
// returns the position to zero. Kernel taps that were never loaded read
// as zero from reset; no clearing pass is needed. The block accepts no
// item while a sample is being worked on, but a load may be accepted
// while a previous result still waits in the output register.
module causal_kernel_convolution_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  s_valid,
    output logic                  s_ready,
    input  cconv_pkg::in_item_t   s_data,
    output logic                  m_valid,
    input  logic                  m_ready,
    output cconv_pkg::out_item_t  m_data
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_ISSUE,
        ST_DRAIN,
        ST_HOLD
    } state_t;

    state_t                          state_reg;
    logic [cconv_pkg::POS_W-1:0]     pos_reg;
    logic [cconv_pkg::IDX_W-1:0]     tgt_reg;
    logic [cconv_pkg::IDX_W-1:0]     n_reg;
    logic                            rd_vld_reg;
    logic                            drain_reg;
    logic                            last_reg;
    logic                            ovf_reg;
    logic                            m_valid_reg;
    cconv_pkg::out_item_t            out_reg;

    logic                            s_accept;
    logic                            is_push;
    logic                            pos_full;
    cconv_pkg::store_wr_t            st_wr;
    cconv_pkg::store_rd_t            st_rd;
    cconv_pkg::mac_ctl_t             mac_ctl;
    logic [cconv_pkg::DATA_W-1:0]    hist_rdata;
    logic [cconv_pkg::DATA_W-1:0]    kern_rdata;
    logic [cconv_pkg::DATA_W-1:0]    mac_result;

    assign s_ready  = (state_reg == ST_IDLE);
    assign s_accept = s_valid && s_ready;
    assign is_push  = (s_data.command == cconv_pkg::CMD_PUSH);
    assign pos_full = (pos_reg == cconv_pkg::POS_W'(cconv_pkg::TAPS));

    // A load writes the kernel at its tap index; a sample that fits in the
    // column is written into the history at the current position.
    always_comb begin
        st_wr.kern_we = s_accept && !is_push &&
                        (32'(s_data.tap_index) < 32'(cconv_pkg::TAPS));
        st_wr.hist_we = s_accept && is_push && !pos_full;
        st_wr.waddr   = is_push ? pos_reg[cconv_pkg::IDX_W-1:0]
                                : cconv_pkg::IDX_W'(s_data.tap_index);
        st_wr.wdata   = s_data.value;
    end

    // History runs forward from the first sample while the kernel runs back
    // from the current position.
    assign st_rd.hist_addr = n_reg;
    assign st_rd.kern_addr = tgt_reg - n_reg;

    assign mac_ctl.clr      = s_accept && is_push;
    assign mac_ctl.op_valid = rd_vld_reg;

    cconv_store u_store (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .wr         (st_wr),
        .rd         (st_rd),
        .hist_rdata (hist_rdata),
        .kern_rdata (kern_rdata)
    );

    cconv_mac u_mac (
        .aclk    (aclk),
        .aresetn (aresetn),
        .ctl     (mac_ctl),
        .op_a    (hist_rdata),
        .op_b    (kern_rdata),
        .result  (mac_result)
    );

    // Sequencer: issues one history and kernel read per cycle, waits for the
    // products to drain through the multiplier, then hands the sum (or, for a
    // dropped sample, a zero) to the output register once that register is free.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            pos_reg     <= '0;
            rd_vld_reg  <= 1'b0;
            drain_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            // Every issue cycle places one read on the store.
            rd_vld_reg <= (state_reg == ST_ISSUE);
            if (m_valid_reg && m_ready && (state_reg != ST_HOLD)) begin
                m_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                ST_IDLE: begin
                    if (s_accept && is_push) begin
                        last_reg <= s_data.last_of_column;
                        if (pos_full) begin
                            ovf_reg   <= 1'b1;
                            pos_reg   <= s_data.last_of_column ? '0 : pos_reg;
                            state_reg <= ST_HOLD;
                        end else begin
                            ovf_reg   <= 1'b0;
                            tgt_reg   <= pos_reg[cconv_pkg::IDX_W-1:0];
                            n_reg     <= '0;
                            pos_reg   <= s_data.last_of_column ? '0
                                         : pos_reg + cconv_pkg::POS_W'(1);
                            state_reg <= ST_ISSUE;
                        end
                    end
                end
                ST_ISSUE: begin
                    n_reg <= n_reg + cconv_pkg::IDX_W'(1);
                    if (n_reg == tgt_reg) begin
                        drain_reg <= 1'b0;
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN: begin
                    drain_reg <= 1'b1;
                    if (drain_reg) begin
                        state_reg <= ST_HOLD;
                    end
                end
                ST_HOLD: begin
                    if (!m_valid_reg || m_ready) begin
                        out_reg.result     <= ovf_reg ? '0 : mac_result;
                        out_reg.column_end <= last_reg;
                        out_reg.overflow   <= ovf_reg;
                        m_valid_reg        <= 1'b1;
                        state_reg          <= ST_IDLE;
                    end
                end
                default: begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = out_reg;

`ifndef NO_ASSERTIONS
    a_pos_range: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= cconv_pkg::POS_W'(cconv_pkg::TAPS))
        else $error("column position beyond kernel length");

    a_issue_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_ISSUE) |-> (n_reg <= tgt_reg))
        else $error("history read beyond current position");

    a_ovf_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_data.overflow) |-> (m_data.result == '0))
        else $error("dropped sample carries a non-zero result");

    a_sat_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_data.result <= cconv_pkg::ONE_Q31))
        else $error("result exceeds one");

    a_no_ops_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg == ST_IDLE) |=> !rd_vld_reg)
        else $error("multiplier fed outside a sample");
`endif

endmodule

// ----- tb/sv/causal_kernel_convolution_core_tb.sv -----
// ---------------------------------------------------------------------------
// Causal kernel convolution core testbench
// Drives load and sample items into the core, predicts every result from a
// private model of the kernel, the column history and the column position,
// and compares each result with the oldest prediction still outstanding.
// ---------------------------------------------------------------------------
module causal_kernel_convolution_core_tb;

    // A scoreboard that keeps its own copy of the kernel, the samples of the
    // current column and the position within it. Predictions are made when a
    // sample item is accepted and retired in order as results arrive.
    class conv_scoreboard;
        logic [31:0]          kernel [cconv_pkg::TAPS];
        logic [31:0]          history [cconv_pkg::TAPS];
        int unsigned          position;
        cconv_pkg::out_item_t pending_results [$];
        int                   failures;

        function new();
            foreach (kernel[i]) begin
                kernel[i]  = '0;
                history[i] = '0;
            end
            position = 0;
            failures = 0;
        endfunction

        // Sum of truncated products along the column, clipped at one.
        function logic [31:0] causal_sum(int unsigned pos);
            logic [63:0] acc;
            logic [63:0] prod;
            acc = '0;
            for (int n = 0; n <= pos; n++) begin
                prod = {32'b0, history[n]} * {32'b0, kernel[pos - n]};
                acc += prod >> 31;
                if (acc >= {32'b0, cconv_pkg::ONE_Q31})
                    return cconv_pkg::ONE_Q31;
            end
            return acc[31:0];
        endfunction

        function void note_accepted(cconv_pkg::in_item_t it);
            cconv_pkg::out_item_t want;
            if (it.command == cconv_pkg::CMD_LOAD) begin
                kernel[it.tap_index] = it.value;
                return;
            end
            want.column_end = it.last_of_column;
            if (position >= cconv_pkg::TAPS) begin
                want.result   = '0;
                want.overflow = 1'b1;
                position      = it.last_of_column ? 0 : cconv_pkg::TAPS;
            end else begin
                history[position] = it.value;
                want.result       = causal_sum(position);
                want.overflow     = 1'b0;
                position          = it.last_of_column ? 0 : position + 1;
            end
            pending_results.push_back(want);
        endfunction

        function void check_result(cconv_pkg::out_item_t got);
            cconv_pkg::out_item_t want;
            if (pending_results.size() == 0) begin
                failures++;
                if (failures <= 10)
                    $display("unexpected result: result=%h column_end=%b overflow=%b",
                             got.result, got.column_end, got.overflow);
                return;
            end
            want = pending_results.pop_front();
            if (got.result !== want.result || got.column_end !== want.column_end ||
                got.overflow !== want.overflow) begin
                failures++;
                if (failures <= 10)
                    $display({"mismatch: expected result=%h column_end=%b overflow=%b, ",
                              "got result=%h column_end=%b overflow=%b"},
                             want.result, want.column_end, want.overflow,
                             got.result, got.column_end, got.overflow);
            end
        endfunction
    endclass

    logic                 aclk    = 1'b0;
    logic                 aresetn = 1'b0;
    logic                 s_valid = 1'b0;
    logic                 s_ready;
    cconv_pkg::in_item_t  s_data  = '0;
    logic                 m_valid;
    logic                 m_ready = 1'b0;
    cconv_pkg::out_item_t m_data;

    conv_scoreboard sb;

    // Percentages of cycles in which the sender holds back or the receiver
    // refuses a result; each phase of the run sets its own pair.
    int tx_idle_pct = 0;
    int rx_stall_pct = 0;

    // The first random column is made long enough to overrun the kernel.
    bit long_column_done = 1'b0;

    causal_kernel_convolution_core dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // The receiver refuses results at random in the stalling phases.
    always @(posedge aclk) begin
        m_ready <= ($urandom_range(99) >= rx_stall_pct);
    end

    // Values are sampled just after the edge, before any update made at it,
    // so a result is taken exactly when the core saw valid and ready high.
    always @(posedge aclk) begin
        if (aresetn && m_valid && m_ready)
            sb.check_result(m_data);
    end

    function automatic cconv_pkg::in_item_t mk_load(logic [4:0] idx, logic [31:0] v,
                                                    logic last);
        cconv_pkg::in_item_t it;
        it.command        = cconv_pkg::CMD_LOAD;
        it.tap_index      = idx;
        it.value          = v;
        it.last_of_column = last;
        return it;
    endfunction

    // The tap index of a sample item means nothing, so it is left random.
    function automatic cconv_pkg::in_item_t mk_push(logic [31:0] v, logic last);
        cconv_pkg::in_item_t it;
        it.command        = cconv_pkg::CMD_PUSH;
        it.tap_index      = $urandom_range(cconv_pkg::TAPS - 1);
        it.value          = v;
        it.last_of_column = last;
        return it;
    endfunction

    function automatic logic [31:0] pick_sample();
        case ($urandom_range(3))
            0: return $urandom;
            1: return $urandom >> $urandom_range(1, 31);
            2: begin
                case ($urandom_range(4))
                    0: return 32'h0000_0000;
                    1: return 32'h0000_0001;
                    2: return 32'h7FFF_FFFF;
                    3: return cconv_pkg::ONE_Q31;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            default: return $urandom_range(cconv_pkg::ONE_Q31);
        endcase
    endfunction

    // Weights are mostly small so that sums do not always reach one.
    function automatic logic [31:0] pick_weight();
        if ($urandom_range(99) < 70)
            return $urandom >> $urandom_range(3, 31);
        return pick_sample();
    endfunction

    // Presents one item and holds it until the core accepts it. Valid is only
    // lowered when a gap is wanted, so back-to-back items keep it high.
    task automatic send(cconv_pkg::in_item_t it);
        if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
            s_valid <= 1'b0;
            do
                @(posedge aclk);
            while ($urandom_range(99) < tx_idle_pct);
        end
        s_valid <= 1'b1;
        s_data  <= it;
        do
            @(posedge aclk);
        while (!s_ready);
        sb.note_accepted(it);
    endtask

    // Holds the sender back until every predicted result has come out. The
    // loop waits on an edge before it checks, so valid is never driven twice at one edge.
    task automatic wait_for_results();
        s_valid <= 1'b0;
        do
            @(posedge aclk);
        while (sb.pending_results.size() != 0);
    endtask

    // Short hand-made sequence: full-scale and above-one values, saturation,
    // the smallest non-zero product, a zero kernel front, a load carrying a
    // stray last-of-column flag and loads at both ends of the kernel.
    task automatic run_directed();
        send(mk_load(5'd0, cconv_pkg::ONE_Q31, 1'b1));
        send(mk_load(5'd31, 32'hFFFF_FFFF, 1'b0));
        send(mk_push(cconv_pkg::ONE_Q31, 1'b0));
        send(mk_push(32'h0000_0000, 1'b0));
        send(mk_push(32'hFFFF_FFFF, 1'b1));
        send(mk_load(5'd0, 32'h0000_0001, 1'b0));
        send(mk_load(5'd1, 32'h4000_0000, 1'b1));
        send(mk_push(32'hFFFF_FFFF, 1'b0));
        send(mk_push(32'h0000_0002, 1'b0));
        send(mk_push(32'h1234_5678, 1'b1));
        send(mk_load(5'd0, 32'h0000_0000, 1'b0));
        send(mk_load(5'd1, 32'h0000_0000, 1'b0));
        send(mk_push(32'hFFFF_FFFF, 1'b1));
        send(mk_load(5'd0, 32'h7FFF_FFFF, 1'b0));
        send(mk_load(5'd16, 32'h2AAA_AAAA, 1'b0));
        send(mk_push(32'h7FFF_FFFF, 1'b0));
        send(mk_push(32'h5555_5555, 1'b0));
        send(mk_push(32'hAAAA_AAAA, 1'b1));
        send(mk_load(5'd0, 32'h0001_0000, 1'b0));
        send(mk_push(32'h0000_0001, 1'b1));
    endtask

    // Random traffic built from well-formed pieces: kernel reloads, whole or
    // partial, and columns of random length with random content. A few
    // columns overrun the kernel, a few lose their last-of-column flag and
    // run on into the next, and stray loads turn up in mid-column.
    task automatic run_random(int quota);
        int sent;
        int len;
        int klen;
        bit drop_last;
        sent = 0;
        while (sent < quota) begin
            if ($urandom_range(99) < 12) begin
                if ($urandom_range(1)) begin
                    klen = $urandom_range(1, cconv_pkg::TAPS);
                    for (int t = 0; t < cconv_pkg::TAPS; t++) begin
                        send(mk_load(t[4:0], (t < klen) ? pick_weight() : 32'h0,
                                     1'($urandom_range(1))));
                        sent++;
                    end
                end else begin
                    repeat ($urandom_range(1, 4)) begin
                        send(mk_load(5'($urandom_range(cconv_pkg::TAPS - 1)),
                                     pick_weight(), 1'($urandom_range(1))));
                        sent++;
                    end
                end
            end else begin
                if (!long_column_done) begin
                    len = cconv_pkg::TAPS + 3;
                    long_column_done = 1'b1;
                end else begin
                    case ($urandom_range(9))
                        0:       len = cconv_pkg::TAPS;
                        1:       len = $urandom_range(cconv_pkg::TAPS + 1,
                                                      cconv_pkg::TAPS + 4);
                        2:       len = $urandom_range(1, 3);
                        default: len = $urandom_range(1, cconv_pkg::TAPS);
                    endcase
                end
                drop_last = ($urandom_range(99) < 5);
                for (int k = 0; k < len; k++) begin
                    if ($urandom_range(99) < 4) begin
                        send(mk_load(5'($urandom_range(cconv_pkg::TAPS - 1)),
                                     pick_weight(), 1'($urandom_range(1))));
                        sent++;
                    end
                    send(mk_push(pick_sample(), (k == len - 1) && !drop_last));
                    sent++;
                end
            end
        end
    endtask

    initial begin
        int tx_plan [4];
        int rx_plan [4];
        int drain_cycles;
        tx_plan = '{0, 81, 0, 38};
        rx_plan = '{0, 0, 81, 38};
        sb = new();

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        run_directed();
        wait_for_results();

        // Each phase ends with the sender paused until the core is drained.
        for (int p = 0; p < 4; p++) begin
            tx_idle_pct  = tx_plan[p];
            rx_stall_pct = rx_plan[p];
            run_random(483);
            wait_for_results();
        end

        // Everything has been sent; allow the longest sample time once more
        // in case something stray is still on its way out.
        drain_cycles = 0;
        while (sb.pending_results.size() != 0 && drain_cycles < 5000) begin
            @(posedge aclk);
            drain_cycles++;
        end
        repeat (cconv_pkg::TAPS + 8) @(posedge aclk);

        if (sb.pending_results.size() != 0) begin
            $display("%0d results never arrived", sb.pending_results.size());
            sb.failures += sb.pending_results.size();
        end

        if (sb.failures == 0)
            $display("[causal_kernel_convolution_core] OK");
        else
            $display("[causal_kernel_convolution_core] ERROR");
        $finish;
    end

    // A hung handshake ends the run here.
    initial begin
        #15_000_000;
        $display("[causal_kernel_convolution_core] ERROR");
        $finish;
    end

endmodule

// ----- sim.f -----
src/cconv_pkg.sv
src/cconv_store.sv
src/cconv_mac.sv
src/causal_kernel_convolution_core.sv
tb/sv/causal_kernel_convolution_core_tb.sv
